// ===== src/single_wire_pulse_width_decoder_core_assert.svh =====
// Assertion macros for the single-wire pulse width decoder.
// Every macro expects signals named clk and arst_n in the scope where it is used.
`ifndef SINGLE_WIRE_PULSE_WIDTH_DECODER_CORE_ASSERT_SVH
`define SINGLE_WIRE_PULSE_WIDTH_DECODER_CORE_ASSERT_SVH

// The antecedent implies the consequent in the same cycle.
`define SWPWD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define SWPWD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/swpwd_pkg.sv =====
// Shared types and constants for the single-wire pulse width decoder.
// No dependencies; every file but the assertion header imports it.
package swpwd_pkg;

	localparam int CFG_W           = 16;
	localparam int CFG_IDX_W       = 3;
	localparam int OUT_W           = 48;
	localparam int BYTE_W          = 8;
	localparam int RING_DEPTH      = 8;
	localparam int RING_AW         = $clog2(RING_DEPTH);
	localparam int BIT_CNT_W       = 4;
	localparam int TIME_WIDTH_DEF  = 48;
	localparam int COUNT_WIDTH_DEF = 16;

	localparam logic [CFG_W-1:0] HIGH_MAX_RST    = 16'd1100;
	localparam logic [CFG_W-1:0] ZERO_MIN_RST    = 16'd500;
	localparam logic [CFG_W-1:0] BREAK_MIN_RST   = 16'd1000;
	localparam logic [CFG_W-1:0] LOW_MAX_RST     = 16'd2000;
	localparam logic [CFG_W-1:0] IDLE_WINDOW_RST = 16'd2100;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HIGH_MAX    = 3'd0,
		REG_ZERO_MIN    = 3'd1,
		REG_BREAK_MIN   = 3'd2,
		REG_LOW_MAX     = 3'd3,
		REG_IDLE_WINDOW = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		KIND_BYTE  = 1'b0,
		KIND_BREAK = 1'b1
	} kind_t;

	typedef struct packed {
		logic [CFG_W-1:0] high_max;
		logic [CFG_W-1:0] zero_min;
		logic [CFG_W-1:0] break_min;
		logic [CFG_W-1:0] low_max;
		logic [CFG_W-1:0] idle_window;
	} cfg_t;

	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] byte_value;
		logic [OUT_W-1:0]  start_time;
		logic [OUT_W-1:0]  end_time;
	} result_t;

endpackage

// ===== src/swpwd_cfg.sv =====
// Threshold register file of the pulse width decoder.
// Depends on swpwd_pkg.
module swpwd_cfg import swpwd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.high_max    <= HIGH_MAX_RST;
			cfg_q.zero_min    <= ZERO_MIN_RST;
			cfg_q.break_min   <= BREAK_MIN_RST;
			cfg_q.low_max     <= LOW_MAX_RST;
			cfg_q.idle_window <= IDLE_WINDOW_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_HIGH_MAX:    cfg_q.high_max    <= cfg_data;
				REG_ZERO_MIN:    cfg_q.zero_min    <= cfg_data;
				REG_BREAK_MIN:   cfg_q.break_min   <= cfg_data;
				REG_LOW_MAX:     cfg_q.low_max     <= cfg_data;
				REG_IDLE_WINDOW: cfg_q.idle_window <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/swpwd_decode.sv =====
// Input register, phase measurement and bit decoding of the pulse width decoder.
// Depends on swpwd_pkg.
module swpwd_decode import swpwd_pkg::*; #(
	parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    line_level,
	output logic    in_stall,
	input  logic    skid_full,
	input  cfg_t    cfg,
	output logic    res_valid,
	output result_t res
);

	localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

	function automatic logic [CMP_W-1:0] cnt_ext(input logic [COUNT_WIDTH-1:0] v);
		logic [CMP_W+COUNT_WIDTH-1:0] w;
		w = {{CMP_W{1'b0}}, v};
		return w[CMP_W-1:0];
	endfunction

	function automatic logic [CMP_W-1:0] cfg_ext(input logic [CFG_W-1:0] v);
		logic [CMP_W+CFG_W-1:0] w;
		w = {{CMP_W{1'b0}}, v};
		return w[CMP_W-1:0];
	endfunction

	function automatic logic [OUT_W-1:0] time_out(input logic [TIME_WIDTH-1:0] v);
		logic [OUT_W+TIME_WIDTH-1:0] w;
		w = {{OUT_W{1'b0}}, v};
		return w[OUT_W-1:0];
	endfunction

	// input stage
	logic valid_s1;
	logic line_s1;

	// decoder state
	logic                   synced_q,  synced_d;
	logic                   prev_q,    prev_d;
	logic [COUNT_WIDTH-1:0] len_q,     len_d;
	logic [BIT_CNT_W-1:0]   bc_q,      bc_d;
	logic [BYTE_W-1:0]      shift_q,   shift_d;
	logic [TIME_WIDTH-1:0]  time_q,    time_d;
	logic [TIME_WIDTH-1:0]  pstart_q,  pstart_d;
	logic [TIME_WIDTH-1:0]  lbe_q,     lbe_d;
	logic [RING_AW-1:0]     ptr_q,     ptr_d;
	logic [TIME_WIDTH-1:0]  ring_q [RING_DEPTH];
	logic                   ring_we;

	logic                   go;
	logic                   bc_full;
	logic                   end_att;
	logic [COUNT_WIDTH-1:0] len_inc;
	logic [CMP_W-1:0]       dur;

	assign go       = valid_s1 && !skid_full;
	assign in_stall = valid_s1 && skid_full;
	assign bc_full  = bc_q[BIT_CNT_W-1];
	assign len_inc  = (len_q == '1) ? len_q : len_q + 1'b1;
	assign dur      = cnt_ext(len_inc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			line_s1  <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
			line_s1  <= line_level;
		end
	end

	always_comb begin
		synced_d = synced_q;
		prev_d   = prev_q;
		len_d    = len_q;
		bc_d     = bc_q;
		shift_d  = shift_q;
		time_d   = time_q;
		pstart_d = pstart_q;
		lbe_d    = lbe_q;
		ptr_d    = ptr_q;
		ring_we  = 1'b0;
		end_att  = 1'b0;
		res_valid      = 1'b0;
		res.kind       = KIND_BYTE;
		res.byte_value = shift_q;
		res.start_time = time_out(ring_q[ptr_q]);
		res.end_time   = time_out(lbe_q);
		if (go) begin
			time_d = time_q + 1'b1;
			if (!synced_q) begin
				if (line_s1) begin
					synced_d = 1'b1;
					prev_d   = 1'b1;
					pstart_d = time_q;
					len_d    = '0;
				end
			end else if (line_s1 == prev_q) begin
				len_d = len_inc;
				if (bc_full && dur >= cfg_ext(cfg.idle_window)) begin
					end_att = 1'b1;
				end
			end else begin
				if (prev_q) begin
					if (dur > cfg_ext(cfg.high_max)) begin
						end_att = 1'b1;
					end
				end else if (dur > cfg_ext(cfg.low_max)) begin
					end_att = 1'b1;
				end else if (dur > cfg_ext(cfg.break_min)) begin
					if (bc_q != '0) begin
						end_att = 1'b1;
					end else begin
						res_valid      = 1'b1;
						res.kind       = KIND_BREAK;
						res.byte_value = '0;
						res.start_time = time_out(pstart_q);
						res.end_time   = time_out(time_q);
					end
				end else begin
					shift_d = {(dur <= cfg_ext(cfg.zero_min)), shift_q[BYTE_W-1:1]};
					ring_we = 1'b1;
					ptr_d   = ptr_q + 1'b1;
					if (!bc_full) begin
						bc_d = bc_q + 1'b1;
					end
					lbe_d = time_q;
				end
				prev_d   = line_s1;
				pstart_d = time_q;
				len_d    = '0;
			end
			if (end_att) begin
				res_valid = bc_full;
				bc_d      = '0;
				shift_d   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			synced_q <= 1'b0;
			prev_q   <= 1'b0;
			len_q    <= '0;
			bc_q     <= '0;
			shift_q  <= '0;
			time_q   <= '0;
			pstart_q <= '0;
			lbe_q    <= '0;
			ptr_q    <= '0;
		end else begin
			synced_q <= synced_d;
			prev_q   <= prev_d;
			len_q    <= len_d;
			bc_q     <= bc_d;
			shift_q  <= shift_d;
			time_q   <= time_d;
			pstart_q <= pstart_d;
			lbe_q    <= lbe_d;
			ptr_q    <= ptr_d;
		end
	end

	// bit start ring: no reset, only read once eight bits have been written
	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_q[ptr_q] <= pstart_q;
		end
	end

endmodule

// ===== src/swpwd_out.sv =====
// Result register with one skid entry for the pulse width decoder.
// Depends on swpwd_pkg.
module swpwd_out import swpwd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    res_valid,
	input  result_t res,
	output logic    skid_full,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_res
);

	logic    out_valid_q;
	result_t out_res_q;
	logic    skid_valid_q;
	result_t skid_q;
	logic    out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			// drain the skid entry first; the decoder holds while it is full
			out_valid_q  <= skid_valid_q || res_valid;
			skid_valid_q <= 1'b0;
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_res_q <= skid_valid_q ? skid_q : res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign skid_full = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

endmodule

// ===== src/single_wire_pulse_width_decoder_core.sv =====
// Single-wire pulse width decoder: one line sample per request, bytes and breaks out.
// A sample is held in the input register, decoded combinationally, and its result
// goes to the result register or the skid entry. Throughput: one sample per cycle,
// set by the single decode stage; the input stalls only while the skid entry is full.
// Reset (arst_n, asynchronous, active low) clears control state and loads default thresholds.
// Depends on swpwd_pkg, swpwd_cfg, swpwd_decode and swpwd_out.
module single_wire_pulse_width_decoder_core import swpwd_pkg::*; #(
	parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration writes
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	// sample request channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 line_level,
	// result request channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 result_kind,
	output logic [BYTE_W-1:0]    byte_value,
	output logic [OUT_W-1:0]     start_sample,
	output logic [OUT_W-1:0]     end_sample
);

	cfg_t    cfg;
	logic    res_valid;
	result_t res;
	logic    skid_full;
	result_t out_res;

	// Threshold registers; the user must write them only while the decoder is idle (not enforced).
	swpwd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Register the sample, measure the phase that ends at an edge, shift in
	// bits, and flag a break, a completed byte or an idle timeout. Hold the
	// input register while the skid entry is occupied.
	swpwd_decode #(
		.TIME_WIDTH  (TIME_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.line_level (line_level),
		.in_stall   (in_stall),
		.skid_full  (skid_full),
		.cfg        (cfg),
		.res_valid  (res_valid),
		.res        (res)
	);

	// Result register plus one skid entry, so one waiting result does not block
	// the next sample; the input stalls while the skid entry is full.
	swpwd_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.skid_full (skid_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	// Drive the payload ports from the result register.
	assign result_kind  = out_res.kind;
	assign byte_value   = out_res.byte_value;
	assign start_sample = out_res.start_time;
	assign end_sample   = out_res.end_time;

endmodule

// ===== src/swpwd_checker.sv =====
// Port-level checks for the single-wire pulse width decoder, bound to the top level.
// Depends on swpwd_pkg and single_wire_pulse_width_decoder_core_assert.svh.
`include "single_wire_pulse_width_decoder_core_assert.svh"

module swpwd_checker import swpwd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic              result_kind,
	input logic [BYTE_W-1:0] byte_value,
	input logic [OUT_W-1:0]  start_sample,
	input logic [OUT_W-1:0]  end_sample
);

	// The input only stalls while a result is waiting at the output.
	`SWPWD_ASSERT_IMPL(a_stall_needs_result, in_stall, out_valid, "input stalled with no result pending")

	// A break carries no byte.
	`SWPWD_ASSERT_IMPL(a_break_byte_zero, out_valid && result_kind, byte_value == '0, "break with nonzero byte")

	// The stall begins only after a held result forced the skid entry to fill.
	`SWPWD_ASSERT_IMPL(a_stall_after_hold, $rose(in_stall), $past(out_valid && out_stall), "stall without prior held result")

	// A held result keeps its payload.
	`SWPWD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(result_kind) && $stable(byte_value) && $stable(start_sample) && $stable(end_sample), "held result changed")

endmodule

bind single_wire_pulse_width_decoder_core swpwd_checker u_swpwd_checker (.*);

// ===== tb/testbench.sv =====
// Testbench for single_wire_pulse_width_decoder_core: drives line samples, predicts the
// decoded bytes and breaks, and checks every result request. Depends on swpwd_pkg and the RTL.
module testbench;
	import swpwd_pkg::*;

	// Decoder predictor plus the store of frames still owed by the block.
	class frame_scoreboard;
		cfg_t th;
		bit synced;
		bit prev_level;
		logic [COUNT_WIDTH_DEF-1:0] run_len;
		logic [BIT_CNT_W-1:0] bits_held;
		logic [BYTE_W-1:0] shreg;
		logic [OUT_W-1:0] clock_now;
		logic [OUT_W-1:0] run_start;
		logic [OUT_W-1:0] last_end;
		logic [OUT_W-1:0] bit_starts [RING_DEPTH];
		logic [RING_AW-1:0] ring_ptr;
		result_t frames_due [$];
		int miscompares;

		function new();
			th.high_max = HIGH_MAX_RST;
			th.zero_min = ZERO_MIN_RST;
			th.break_min = BREAK_MIN_RST;
			th.low_max = LOW_MAX_RST;
			th.idle_window = IDLE_WINDOW_RST;
			synced = 0;
			prev_level = 0;
			run_len = '0;
			bits_held = '0;
			shreg = '0;
			clock_now = '0;
			run_start = '0;
			last_end = '0;
			ring_ptr = '0;
			miscompares = 0;
		endfunction

		function void set_reg(cfg_reg_t r, logic [CFG_W-1:0] v);
			case (r)
				REG_HIGH_MAX:    th.high_max = v;
				REG_ZERO_MIN:    th.zero_min = v;
				REG_BREAK_MIN:   th.break_min = v;
				REG_LOW_MAX:     th.low_max = v;
				REG_IDLE_WINDOW: th.idle_window = v;
				default: ;
			endcase
		endfunction

		// Close the attempt: a full byte is owed, anything shorter is dropped.
		function void close_attempt();
			result_t f;
			if (bits_held >= 8) begin
				f.kind = KIND_BYTE;
				f.byte_value = shreg;
				f.start_time = bit_starts[ring_ptr];
				f.end_time = last_end;
				frames_due.push_back(f);
			end
			bits_held = '0;
			shreg = '0;
		endfunction

		function void decode_sample(logic lvl);
			logic [OUT_W-1:0] t;
			logic [COUNT_WIDTH_DEF:0] dur;
			result_t f;
			t = clock_now;
			clock_now = clock_now + 1'b1;
			if (!synced) begin
				if (lvl) begin
					synced = 1;
					prev_level = 1;
					run_start = t;
					run_len = '0;
				end
				return;
			end
			if (lvl == prev_level) begin
				if (run_len != '1)
					run_len = run_len + 1'b1;
				if (bits_held >= 8 && run_len >= th.idle_window)
					close_attempt();
				return;
			end
			dur = (run_len != '1) ? {1'b0, run_len} + 1'b1 : {1'b0, run_len};
			if (prev_level) begin
				if (dur > th.high_max)
					close_attempt();
			end else if (dur > th.low_max) begin
				close_attempt();
			end else if (dur > th.break_min) begin
				if (bits_held != 0) begin
					close_attempt();
				end else begin
					f.kind = KIND_BREAK;
					f.byte_value = '0;
					f.start_time = run_start;
					f.end_time = t;
					frames_due.push_back(f);
				end
			end else begin
				shreg = {(dur <= th.zero_min), shreg[BYTE_W-1:1]};
				bit_starts[ring_ptr] = run_start;
				ring_ptr = ring_ptr + 1'b1;
				if (bits_held < 8)
					bits_held = bits_held + 1'b1;
				last_end = t;
			end
			prev_level = lvl;
			run_start = t;
			run_len = '0;
		endfunction

		function void match_frame(result_t got);
			result_t want;
			if (frames_due.size() == 0) begin
				miscompares++;
				if (miscompares <= 10)
					$display("unexpected result: kind %0d byte %02h start %0d end %0d",
						got.kind, got.byte_value, got.start_time, got.end_time);
				return;
			end
			want = frames_due.pop_front();
			if (got.kind !== want.kind || got.byte_value !== want.byte_value ||
					got.start_time !== want.start_time || got.end_time !== want.end_time) begin
				miscompares++;
				if (miscompares <= 10)
					$display("mismatch: expected kind %0d byte %02h start %0d end %0d, got kind %0d byte %02h start %0d end %0d",
						want.kind, want.byte_value, want.start_time, want.end_time,
						got.kind, got.byte_value, got.start_time, got.end_time);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_HIGH_MAX;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 line_level = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 result_kind;
	logic [BYTE_W-1:0]    byte_value;
	logic [OUT_W-1:0]     start_sample;
	logic [OUT_W-1:0]     end_sample;

	frame_scoreboard sb;

	// Sender and receiver state, partly set by the main test sequence.
	int samples_sent = 0;
	int burst_left = 0;
	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int stall_run = 0;
	bit stall_on = 1'b0;

	single_wire_pulse_width_decoder_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.line_level(line_level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.byte_value(byte_value),
		.start_sample(start_sample),
		.end_sample(end_sample)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#800000;
		$display("testbench: done, errors");
		$finish;
	end

	// Result side: check each accepted request, then pick the next stall value.
	// A long hold-off, when requested, takes priority; otherwise stall on a
	// random on/off run pattern unless this phase runs the receiver quiet.
	always @(posedge clk) begin
		result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.kind = kind_t'(result_kind);
			got.byte_value = byte_value;
			got.start_time = start_sample;
			got.end_time = end_sample;
			sb.match_frame(got);
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = 600;
			out_stall <= 1'b1;
		end else if (rx_quiet) begin
			out_stall <= 1'b0;
		end else begin
			if (stall_run == 0) begin
				stall_on = !stall_on;
				stall_run = stall_on ? $urandom_range(1, 5) : $urandom_range(1, 12);
			end
			stall_run--;
			out_stall <= stall_on;
		end
	end

	function automatic int pick(int lo, int hi);
		return (hi < lo) ? lo : $urandom_range(hi, lo);
	endfunction

	// Offer one sample and hold it until the block takes it. Between bursts,
	// drop valid for a random gap unless the sender runs quiet.
	task automatic offer_sample(input logic lvl);
		int gap;
		if (!tx_quiet && burst_left == 0) begin
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		if (burst_left > 0)
			burst_left--;
		in_valid <= 1'b1;
		line_level <= lvl;
		do @(posedge clk); while (in_stall);
		sb.decode_sample(lvl);
		samples_sent++;
	endtask

	task automatic drive_phase(input logic lvl, input int len);
		repeat (len) offer_sample(lvl);
	endtask

	// Hold the input idle until every owed result is out, then let the
	// pipeline settle before touching the thresholds.
	task automatic drain_and_pause();
		in_valid <= 1'b0;
		while (sb.frames_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Keep write enable high across the register writes; drop it after the last.
	task automatic write_threshold(input cfg_reg_t r, input logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		@(posedge clk);
		sb.set_reg(r, v);
	endtask

	task automatic load_thresholds(input logic [CFG_W-1:0] hm, zm, bm, lm, iw);
		drain_and_pause();
		write_threshold(REG_HIGH_MAX, hm);
		write_threshold(REG_ZERO_MIN, zm);
		write_threshold(REG_BREAK_MIN, bm);
		write_threshold(REG_LOW_MAX, lm);
		write_threshold(REG_IDLE_WINDOW, iw);
		cfg_we <= 1'b0;
	endtask

	// Send eight bits LSB first at the threshold boundaries: ones at zero_min,
	// zeros at break_min, each followed by a high phase of exactly high_max.
	task automatic drive_byte(input logic [BYTE_W-1:0] v);
		int zm, bm, hm;
		zm = sb.th.zero_min;
		bm = sb.th.break_min;
		hm = sb.th.high_max;
		for (int i = 0; i < BYTE_W; i++) begin
			drive_phase(1'b0, v[i] ? zm : bm);
			drive_phase(1'b1, hm);
		end
	endtask

	// One random frame: mostly well-formed bytes with random content and a
	// random way of closing, plus breaks and plain noise.
	task automatic random_frame(input bit breaks_only);
		int hm, zm, bm, lm, iw, hmax, sel, nbits;
		hm = sb.th.high_max;
		zm = sb.th.zero_min;
		bm = sb.th.break_min;
		lm = sb.th.low_max;
		iw = sb.th.idle_window;
		hmax = (hm < 1) ? 1 : hm;
		sel = breaks_only ? 6 : $urandom_range(0, 9);
		if (sel < 6) begin
			nbits = (sel < 5) ? $urandom_range(8, 11) : $urandom_range(1, 7);
			repeat (nbits) begin
				if ($urandom_range(0, 1))
					drive_phase(1'b0, pick(1, zm));
				else
					drive_phase(1'b0, pick(zm + 1, (bm < lm) ? bm : lm));
				drive_phase(1'b1, pick(1, hmax));
			end
			case ($urandom_range(0, 3))
				0: drive_phase(1'b1, iw + $urandom_range(0, 3));
				1: begin
					drive_phase(1'b0, lm + $urandom_range(1, 3));
					drive_phase(1'b1, pick(1, hmax));
				end
				2: drive_phase(1'b1, $urandom_range(1, 3));
				default: begin
					drive_phase(1'b0, pick(bm + 1, lm));
					drive_phase(1'b1, pick(1, hmax));
				end
			endcase
		end else if (sel < 8) begin
			drive_phase(1'b0, pick(bm + 1, lm));
			drive_phase(1'b1, pick(1, hmax));
		end else begin
			repeat ($urandom_range(1, 6)) begin
				drive_phase(1'b0, $urandom_range(1, lm + 4));
				drive_phase(1'b1, $urandom_range(1, hm + 4));
			end
		end
	endtask

	initial begin
		int phase;
		int budget;
		int hm, zm, bm, lm, iw;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset thresholds: samples before the first high are ignored, then
		// a high phase well inside the default limit.
		drive_phase(1'b0, 5);
		drive_phase(1'b1, 20);

		// Short thresholds: walk the special cases one by one.
		load_thresholds(16'd6, 16'd2, 16'd5, 16'd8, 16'd10);
		drive_byte(8'h5A);
		drive_phase(1'b1, 10);
		// more than eight bits: only the last eight survive
		drive_phase(1'b0, 2);
		drive_phase(1'b1, 6);
		drive_phase(1'b0, 5);
		drive_phase(1'b1, 6);
		drive_byte(8'h96);
		drive_phase(1'b1, 10);
		// high phase one past the limit closes the byte at the next fall
		drive_byte(8'h0F);
		drive_phase(1'b1, 1);
		drive_phase(1'b0, 2);
		drive_phase(1'b1, 16);
		// low phase one past the limit
		drive_byte(8'hF0);
		drive_phase(1'b0, 9);
		drive_phase(1'b1, 6);
		// break-length low after a full byte closes it instead of breaking
		drive_byte(8'h81);
		drive_phase(1'b0, 6);
		drive_phase(1'b1, 6);
		// break-length low after a few bits drops them
		repeat (3) begin
			drive_phase(1'b0, 2);
			drive_phase(1'b1, 3);
		end
		drive_phase(1'b0, 8);
		drive_phase(1'b1, 6);
		// too few bits, then idle: nothing comes out
		repeat (5) begin
			drive_phase(1'b0, 5);
			drive_phase(1'b1, 2);
		end
		drive_phase(1'b1, 12);
		// clean breaks at both ends of the window
		drive_phase(1'b0, 6);
		drive_phase(1'b1, 6);
		drive_phase(1'b0, 8);
		drive_phase(1'b1, 6);

		// Bottom of the range: one-sample bit phases, then longer ones; idle closes at once.
		load_thresholds(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
		repeat (10) begin
			drive_phase(1'b0, 1);
			drive_phase(1'b1, 1);
		end
		drive_phase(1'b1, 3);
		drive_phase(1'b0, 2);
		drive_phase(1'b1, 1);

		// All zero: every low is too long.
		load_thresholds(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		repeat (4) random_frame(1'b0);

		// Random phases: new thresholds, new idling mode, then random frames.
		// Phase two holds off the receiver for a long stretch on a stream of
		// breaks so the block backs up and stalls its input.
		phase = 0;
		while (phase < 5) begin
			if (phase == 2) begin
				hm = 4;
				zm = 2;
				bm = 4;
				lm = 7;
				iw = 9;
			end else if ($urandom_range(0, 3) != 0) begin
				zm = $urandom_range(1, 4);
				bm = zm + $urandom_range(1, 4);
				lm = bm + $urandom_range(1, 4);
				hm = $urandom_range(1, 8);
				iw = $urandom_range(1, 20);
			end else begin
				hm = $urandom_range(0, 12);
				zm = $urandom_range(0, 12);
				bm = $urandom_range(0, 12);
				lm = $urandom_range(0, 12);
				iw = $urandom_range(0, 12);
			end
			load_thresholds(hm, zm, bm, lm, iw);
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			if (phase == 2) begin
				tx_quiet = 1'b0;
				rx_quiet = 1'b0;
				hold_req = 1'b1;
			end
			budget = samples_sent + 100;
			while (samples_sent < budget)
				random_frame(phase == 2);
			phase++;
		end

		// Drain what is still owed, then give the block time to misbehave.
		in_valid <= 1'b0;
		for (int w = 0; w < 5000 && sb.frames_due.size() != 0; w++)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (sb.miscompares == 0 && sb.frames_due.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/swpwd_pkg.sv
src/swpwd_cfg.sv
src/swpwd_decode.sv
src/swpwd_out.sv
src/single_wire_pulse_width_decoder_core.sv
src/swpwd_checker.sv
tb/testbench.sv
